### src/lcdsw_pkg.sv
// Package for the LCD controller serial writer: item types, command codes,
// frame constants and the controller/datapath command and status structs.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package lcdsw_pkg;

  // Input item command codes.
  localparam logic [1:0] CMD_WR_START = 2'd0;
  localparam logic [1:0] CMD_WR_CONT  = 2'd1;
  localparam logic [1:0] CMD_COMMAND  = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  // Frame codes sent ahead of the address or the command word.
  localparam logic [2:0] WRITE_CODE   = 3'd5;
  localparam logic [3:0] COMMAND_CODE = 4'd8;

  // Default shadow store depth.
  localparam int SHADOW_BYTES = 16;

  // Longest frame of one item: 3-bit code, 6-bit address, 8 data bits.
  localparam int FRAME_BITS = 17;
  localparam int CNT_W      = 5;

  // Run lengths per item kind.
  localparam logic [CNT_W-1:0] LEN_WR_START  = CNT_W'(17);
  localparam logic [CNT_W-1:0] LEN_BYTE      = CNT_W'(8);
  localparam logic [CNT_W-1:0] LEN_CMD_FIRST = CNT_W'(12);
  localparam logic [CNT_W-1:0] LEN_READ      = CNT_W'(1);

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] byte_address;
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic       wire_bit;
    logic       release_select;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last_of_run;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the accepted item into the shift register and store
    logic shift;  // move the next result into the output register
    logic last;   // the result being moved is the final one of its item
  } lcdsw_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic select_active;
  } lcdsw_stat_t;

  // Number of results caused by an item.
  function automatic logic [CNT_W-1:0] run_length(input logic [1:0] cmd,
                                                  input logic first);
    logic [CNT_W-1:0] len;
    case (cmd)
      CMD_WR_START: len = LEN_WR_START;
      CMD_WR_CONT:  len = LEN_BYTE;
      CMD_COMMAND:  len = first ? LEN_CMD_FIRST : LEN_BYTE;
      default:      len = LEN_READ;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### src/lcdsw_ctrl.sv
// Controller of the LCD controller serial writer: run state, result counter
// and output valid flag. Uses lcdsw_pkg; drives the datapath via lcdsw_cmd_t.
`default_nettype none

module lcdsw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lcdsw_pkg::in_item_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lcdsw_pkg::lcdsw_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        st_r, st_nxt;
  logic [lcdsw_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        adv;
  logic                        final_bit;
  logic                        load;

  // A result moves out whenever the output register is free or being taken.
  assign adv       = (st_r == ST_RUN) && (!out_valid_r || out_ready);
  assign final_bit = (cnt_r == lcdsw_pkg::CNT_W'(1));
  assign in_ready  = (st_r == ST_IDLE) || (adv && final_bit);
  assign load      = in_valid && in_ready;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    if (load) begin
      st_nxt  = ST_RUN;
      cnt_nxt = lcdsw_pkg::run_length(in_data.command, in_data.first_of_frame);
    end else if (adv) begin
      cnt_nxt = cnt_r - lcdsw_pkg::CNT_W'(1);
      if (final_bit) begin
        st_nxt = ST_IDLE;
      end
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cmd.load  = load;
  assign cmd.shift = adv;
  assign cmd.last  = final_bit;

endmodule

`default_nettype wire

### src/lcdsw_dpath.sv
// Datapath of the LCD controller serial writer: frame shift register, shadow
// store, burst pointer, select flag and output register. Uses lcdsw_pkg.
`default_nettype none

module lcdsw_dpath #(
  parameter int SHADOW_BYTES = lcdsw_pkg::SHADOW_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lcdsw_pkg::in_item_t   in_data,
  input  wire lcdsw_pkg::lcdsw_cmd_t cmd,
  output lcdsw_pkg::out_item_t       out_data,
  output lcdsw_pkg::lcdsw_stat_t     stat
);

  localparam int PW = $clog2(SHADOW_BYTES);
  localparam logic [PW-1:0] PTR_LAST = PW'(SHADOW_BYTES - 1);

  logic [7:0]                          store_r [SHADOW_BYTES];
  logic [PW-1:0]                       ptr_r, ptr_nxt;
  logic                                sel_r, sel_nxt;
  logic [lcdsw_pkg::FRAME_BITS-1:0]    sh_r, sh_nxt;
  logic                                rd_mode_r;
  logic                                eof_r;
  logic [7:0]                          rd_byte_r;
  lcdsw_pkg::out_item_t                out_r;
  logic [PW-1:0]                       addr;
  logic [PW-1:0]                       addr_inc;
  logic [PW-1:0]                       ptr_inc;
  logic                                is_read;

  assign addr     = PW'(in_data.byte_address);
  assign addr_inc = (addr == PTR_LAST) ? '0 : addr + PW'(1);
  assign ptr_inc  = (ptr_r == PTR_LAST) ? '0 : ptr_r + PW'(1);
  assign is_read  = (in_data.command == lcdsw_pkg::CMD_READ);

  // Frame image, first bit at the top of the shift register.
  always_comb begin
    sh_nxt  = sh_r;
    ptr_nxt = ptr_r;
    sel_nxt = sel_r;
    if (cmd.load) begin
      case (in_data.command)
        lcdsw_pkg::CMD_WR_START: begin
          sh_nxt  = {lcdsw_pkg::WRITE_CODE, 1'b0, in_data.byte_address, 1'b0,
                     in_data.data_byte};
          ptr_nxt = addr_inc;
          sel_nxt = 1'b1;
        end
        lcdsw_pkg::CMD_WR_CONT: begin
          sh_nxt  = {in_data.data_byte, 9'b0};
          ptr_nxt = ptr_inc;
        end
        lcdsw_pkg::CMD_COMMAND: begin
          if (in_data.first_of_frame) begin
            sh_nxt  = {lcdsw_pkg::COMMAND_CODE, in_data.data_byte, 5'b0};
            sel_nxt = 1'b1;
          end else begin
            sh_nxt = {in_data.data_byte, 9'b0};
          end
        end
        default: begin
          sh_nxt = '0;
        end
      endcase
      if (!is_read && in_data.end_of_frame) begin
        sel_nxt = 1'b0;
      end
    end else if (cmd.shift) begin
      sh_nxt = {sh_r[lcdsw_pkg::FRAME_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SHADOW_BYTES; i++) begin
        store_r[i] <= 8'h00;
      end
    end else if (cmd.load) begin
      if (in_data.command == lcdsw_pkg::CMD_WR_START) begin
        store_r[addr] <= in_data.data_byte;
      end else if (in_data.command == lcdsw_pkg::CMD_WR_CONT) begin
        store_r[ptr_r] <= in_data.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      sel_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (cmd.load) begin
      rd_mode_r <= is_read;
      eof_r     <= in_data.end_of_frame;
      rd_byte_r <= store_r[addr];
    end
    if (cmd.shift) begin
      out_r.wire_bit       <= rd_mode_r ? 1'b0 : sh_r[lcdsw_pkg::FRAME_BITS-1];
      out_r.release_select <= !rd_mode_r && cmd.last && eof_r;
      out_r.read_data      <= rd_mode_r ? rd_byte_r : 8'h00;
      out_r.read_valid     <= rd_mode_r;
      out_r.last_of_run    <= cmd.last;
    end
  end

  assign out_data           = out_r;
  assign stat.select_active = sel_r;

endmodule

`default_nettype wire

### src/lcd_controller_serial_writer.sv
// LCD controller serial writer, top level. An accepted item is loaded into the
// frame shift register and the run state; its first result then moves into the
// output register. Results per item: 17 for a write start, 8 or 12 for a
// command, 8 for a continuation, 1 for a read; one result per cycle while the
// output register is free or being taken. Reset (rst_n, synchronous, active low)
// clears the shadow store, burst pointer, select flag and all handshake state.
`default_nettype none

module lcd_controller_serial_writer #(
  parameter int SHADOW_BYTES = lcdsw_pkg::SHADOW_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lcdsw_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lcdsw_pkg::out_item_t      out_data
);

  // The controller counts the results of the current item and owns the
  // output valid flag. A new item is taken in the cycle the final result of
  // the previous one moves into the output register, so runs follow each
  // other without a gap, while a waiting result is still held for the sink.
  lcdsw_pkg::lcdsw_cmd_t  cmd;
  lcdsw_pkg::lcdsw_stat_t stat;

  lcdsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath builds the frame image of an item at acceptance, updates the
  // shadow store and the burst pointer then, and shifts one bit per result
  // into the output register, most significant bit first.
  lcdsw_dpath #(
    .SHADOW_BYTES (SHADOW_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data),
    .stat     (stat)
  );

  // A read result is always the single and final result of its item.
  a_read_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> out_data.last_of_run && !out_data.wire_bit)
    else $error("read result not marked as final");

  // Select release can only be flagged on the final bit of a run.
  a_release_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.release_select |-> out_data.last_of_run && !out_data.read_valid)
    else $error("select release on a bit other than the last");

  // An item other than a read that ends its frame leaves select inactive.
  a_select_released: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_frame
      && (in_data.command != lcdsw_pkg::CMD_READ) |=> !stat.select_active)
    else $error("select still active after end of frame");

endmodule

`default_nettype wire

### sim/lcd_serial_frame_checker.sv
// Checker for the LCD controller serial writer: predicts every strobe and read result.
// It compares each result with the oldest prediction. Depends on lcdsw_pkg for the
// item types, the command codes and the frame codes.
`default_nettype none

module lcd_serial_frame_checker
  import lcdsw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_data,
  output int             error_count,
  output int             strobes_pending
);

  logic [7:0] shadow_copy [SHADOW_BYTES];
  logic [3:0] next_burst;
  out_item_t  expected_strobes [$];
  out_item_t  want;

  // Queues the bits of one field, MSB first. The tail field closes the item's run.
  task automatic push_bits(input logic [7:0] value, input int count, input bit tail,
                           input bit eof);
    out_item_t r;
    for (int i = count - 1; i >= 0; i--) begin
      r = '0;
      r.wire_bit       = value[i];
      r.last_of_run    = tail && (i == 0);
      r.release_select = tail && (i == 0) && eof;
      expected_strobes.push_back(r);
    end
  endtask

  task automatic predict_frame_bits(input in_item_t it);
    out_item_t r;
    case (it.command)
      CMD_WR_START: begin
        push_bits(8'(WRITE_CODE), 3, 1'b0, 1'b0);
        push_bits({3'b000, it.byte_address, 1'b0}, 6, 1'b0, 1'b0);
        push_bits(it.data_byte, 8, 1'b1, it.end_of_frame);
        shadow_copy[it.byte_address] = it.data_byte;
        next_burst = it.byte_address + 4'd1;
      end
      CMD_WR_CONT: begin
        push_bits(it.data_byte, 8, 1'b1, it.end_of_frame);
        shadow_copy[next_burst] = it.data_byte;
        next_burst = next_burst + 4'd1;
      end
      CMD_COMMAND: begin
        if (it.first_of_frame) begin
          push_bits(8'(COMMAND_CODE), 4, 1'b0, 1'b0);
        end
        push_bits(it.data_byte, 8, 1'b1, it.end_of_frame);
      end
      default: begin
        r = '0;
        r.read_data   = shadow_copy[it.byte_address];
        r.read_valid  = 1'b1;
        r.last_of_run = 1'b1;
        expected_strobes.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (shadow_copy[i]) shadow_copy[i] = 8'h00;
      next_burst  = '0;
      expected_strobes.delete();
      error_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_strobes.size() == 0) begin
          $error("result %0h arrived with no prediction waiting", out_data);
          error_count++;
        end else begin
          want = expected_strobes.pop_front();
          check_field("wire_bit", 8'(want.wire_bit), 8'(out_data.wire_bit));
          check_field("release_select", 8'(want.release_select), 8'(out_data.release_select));
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
          check_field("last_of_run", 8'(want.last_of_run), 8'(out_data.last_of_run));
        end
      end
      if (in_valid && in_ready)
        predict_frame_bits(in_data);
    end
    strobes_pending = expected_strobes.size();
  end

endmodule

`default_nettype wire

### sim/lcd_controller_serial_writer_tb.sv
// Testbench top for the LCD controller serial writer: clock, reset, stimulus and verdict.
// Depends on lcdsw_pkg, the block itself and lcd_serial_frame_checker.
`default_nettype none

module lcd_controller_serial_writer_tb;
  import lcdsw_pkg::*;

  // Directed items come first; each random phase then sends frames until the total grows by this many items.
  localparam int DIRECTED_ITEMS = 21;
  localparam int PHASE_ITEMS    = 88;
  localparam int ITEM_W         = $bits(in_item_t);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int error_count;
  int strobes_pending;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #1 clk = ~clk;

  lcd_controller_serial_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lcd_serial_frame_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .error_count     (error_count),
    .strobes_pending (strobes_pending)
  );

  // The receiver decides afresh every cycle whether it takes a result. All
  // inputs of the block change on the falling edge, half a period away from
  // the edge at which the block and the checker sample them.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [3:0] addr,
                                         input logic [7:0] data, input logic first,
                                         input logic eof);
    in_item_t it;
    it.command        = cmd;
    it.byte_address   = addr;
    it.data_byte      = data;
    it.first_of_frame = first;
    it.end_of_frame   = eof;
    return it;
  endfunction

  // Offers one item, starting on a falling edge, and returns on the falling
  // edge after the item was taken. Valid is left high on return, so a
  // back-to-back item sees only one assignment of valid in that time step.
  // During an idle cycle valid is low and the payload carries junk that the
  // block must not pick up.
  task automatic send_item(input in_item_t it);
    logic [ITEM_W-1:0] junk;
    while ($urandom_range(99) < send_idle_pct) begin
      junk = ITEM_W'($urandom());
      in_valid <= 1'b0;
      in_data  <= junk;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // One random frame. Most frames are well formed: a write start followed by
  // a burst of continuations, or a command frame that opens with the prefix.
  // Reads, which do not touch select, are mixed in, and a fifth of the frames
  // are single items with every field random, which also produces broken
  // sequences such as continuations and commands with no open frame.
  task automatic send_random_frame();
    int                kind;
    int                burst_len;
    bit                close_frame;
    logic [ITEM_W-1:0] raw;
    kind        = $urandom_range(9);
    burst_len   = $urandom_range(5);
    close_frame = ($urandom_range(7) != 0);
    if (kind <= 3) begin
      send_item(make_item(CMD_WR_START, 4'($urandom()), 8'($urandom()), 1'($urandom()),
                          (burst_len == 0) && close_frame));
      for (int i = 0; i < burst_len; i++) begin
        send_item(make_item(CMD_WR_CONT, 4'($urandom()), 8'($urandom()), 1'($urandom()),
                            (i == burst_len - 1) && close_frame));
      end
    end else if (kind <= 5) begin
      burst_len = burst_len % 4;
      send_item(make_item(CMD_COMMAND, 4'($urandom()), 8'($urandom()), 1'b1,
                          (burst_len == 0) && close_frame));
      for (int i = 0; i < burst_len; i++) begin
        send_item(make_item(CMD_COMMAND, 4'($urandom()), 8'($urandom()), 1'b0,
                            (i == burst_len - 1) && close_frame));
      end
    end else if (kind <= 7) begin
      for (int i = 0; i <= burst_len % 3; i++) begin
        send_item(make_item(CMD_READ, 4'($urandom()), 8'($urandom()), 1'($urandom()),
                            1'($urandom())));
      end
    end else begin
      raw = ITEM_W'($urandom());
      send_item(raw);
    end
  endtask

  initial begin
    // Reset is held at the start and released on a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with no idling on either side.
    // Reads of a store that is still in its cleared state, with the flags
    // that a read ignores set on the second one.
    send_item(make_item(CMD_READ, 4'd0, 8'h00, 1'b0, 1'b0));
    send_item(make_item(CMD_READ, 4'd15, 8'hFF, 1'b1, 1'b1));
    // A continuation with no open frame writes at the reset burst pointer.
    send_item(make_item(CMD_WR_CONT, 4'd0, 8'hA5, 1'b0, 1'b0));
    // A command without the prefix, and an end of frame, while select is off.
    send_item(make_item(CMD_COMMAND, 4'd0, 8'h00, 1'b0, 1'b1));
    // A burst from the lowest address; first_of_frame is ignored on a write.
    send_item(make_item(CMD_WR_START, 4'd0, 8'h00, 1'b1, 1'b0));
    send_item(make_item(CMD_WR_CONT, 4'd0, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(CMD_WR_CONT, 4'd0, 8'h5A, 1'b0, 1'b1));
    // A burst from the top address: the pointer wraps round to zero.
    send_item(make_item(CMD_WR_START, 4'd15, 8'hFF, 1'b0, 1'b0));
    send_item(make_item(CMD_WR_CONT, 4'd15, 8'h3C, 1'b1, 1'b1));
    send_item(make_item(CMD_READ, 4'd15, 8'h00, 1'b0, 1'b0));
    send_item(make_item(CMD_READ, 4'd0, 8'h00, 1'b0, 1'b0));
    send_item(make_item(CMD_READ, 4'd1, 8'h00, 1'b0, 1'b0));
    // Command frames, with and without the prefix.
    send_item(make_item(CMD_COMMAND, 4'd15, 8'hFF, 1'b1, 1'b0));
    send_item(make_item(CMD_COMMAND, 4'd0, 8'h81, 1'b0, 1'b0));
    send_item(make_item(CMD_COMMAND, 4'd0, 8'h00, 1'b1, 1'b1));
    // A single write that closes its own frame, then continuations after it.
    send_item(make_item(CMD_WR_START, 4'd8, 8'h80, 1'b0, 1'b1));
    send_item(make_item(CMD_WR_CONT, 4'd3, 8'h01, 1'b0, 1'b0));
    send_item(make_item(CMD_READ, 4'd9, 8'h00, 1'b0, 1'b0));
    send_item(make_item(CMD_READ, 4'd8, 8'h00, 1'b0, 1'b0));
    send_item(make_item(CMD_WR_CONT, 4'd0, 8'h7E, 1'b0, 1'b1));
    send_item(make_item(CMD_READ, 4'd10, 8'h00, 1'b0, 1'b0));

    // Random part in four phases: no idling, sender idle, receiver stalling,
    // and both at once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      while (items_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS)
        send_random_frame();
    end
    in_valid <= 1'b0;

    // Drain every predicted result, then keep running so that a stray result
    // after the last expected one is still caught.
    while (strobes_pending != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    if (error_count == 0 && strobes_pending == 0) begin
      $display("** lcd_controller_serial_writer: PASSED **");
    end else begin
      $display("** lcd_controller_serial_writer: FAILED **");
    end
    $finish;
  end

  // Watchdog: the run fails if it has not finished by this time.
  initial begin
    #800000;
    $display("** lcd_controller_serial_writer: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
